>>> sv/sadc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sadc_pkg
// Shared types, codes and constants of the stepper auto-repeat block with
// debounced weight commit.
// ----------------------------------------------------------------------------
package sadc_pkg;

  // Sizes
  localparam int unsigned PRESET_SLOTS  = 256;
  localparam int unsigned WEIGHT_LEVELS = 5;
  localparam int unsigned PCT_PER_LEVEL = 25;

  localparam int unsigned TIMER_W  = 16;
  localparam int unsigned COUNT_W  = 9;
  localparam int unsigned PRESET_W = 8;
  localparam int unsigned WEIGHT_W = 3;
  localparam int unsigned PCT_W    = 7;
  localparam int unsigned HELD_W   = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [TIMER_W-1:0]  TIMER_MAX  = '1;
  localparam logic [COUNT_W-1:0]  SLOTS_CNT  = COUNT_W'(PRESET_SLOTS);
  localparam logic [WEIGHT_W-1:0] WEIGHT_TOP = WEIGHT_W'(WEIGHT_LEVELS - 1);

  // Event codes
  typedef enum logic [2:0] {
    ACT_TICK       = 3'd0,
    ACT_OPEN       = 3'd1,
    ACT_CLOSE      = 3'd2,
    ACT_PRESS      = 3'd3,
    ACT_RELEASE    = 3'd4,
    ACT_HOVER_IN   = 3'd5,
    ACT_HOVER_OUT  = 3'd6
  } action_e;

  // Button codes
  localparam logic [3:0] BTN_PRESET_PREV = 4'd0;
  localparam logic [3:0] BTN_PRESET_NEXT = 4'd1;
  localparam logic [3:0] BTN_WEIGHT_PREV = 4'd2;
  localparam logic [3:0] BTN_WEIGHT_NEXT = 4'd3;
  localparam logic [3:0] BTN_WEIGHT_ICON = 4'd4;
  localparam logic [3:0] BTN_PRESET_ICON = 4'd5;
  localparam logic [3:0] BTN_ANCHOR      = 4'd6;
  localparam logic [3:0] BTN_UNDO        = 4'd7;

  // Held stepper codes (stepper button + 1, zero means none)
  localparam logic [HELD_W-1:0] HELD_NONE = 3'd0;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_DELAY    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_INTERVAL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COMMIT_DEBOUNCE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESET_COUNT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_EDITABLE = 3'd4;

  // One result transaction
  typedef struct packed {
    logic                handled;
    logic [PRESET_W-1:0] preset_index;
    logic                preset_stepped;
    logic [WEIGHT_W-1:0] weight_level;
    logic [PCT_W-1:0]    weight_percent;
    logic                weight_stepped;
    logic                commit_weight;
    logic                close_request;
    logic                undo_request;
  } result_t;

  // Weight level to percent, level times PCT_PER_LEVEL
  function automatic logic [PCT_W-1:0] level_pct(input logic [WEIGHT_W-1:0] lvl);
    logic [PCT_W+WEIGHT_W-1:0] prod;
    prod = lvl * (PCT_W+WEIGHT_W)'(PCT_PER_LEVEL);
    return prod[PCT_W-1:0];
  endfunction

endpackage

>>> sv/stepper_autorepeat_with_debounced_commit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_autorepeat_with_debounced_commit
// Menu stepper event handler: wrap-around preset and weight steppers with
// typematic auto-repeat, debounced weight commit and release requests.
// ----------------------------------------------------------------------------
// Output: the result of an accepted transaction is registered in the output register.
// Throughput: one transaction per cycle while the skid register is empty;
// state update and result are one pass of logic into the state and output
// registers, a skid register holds one extra result during an output stall.
// Reset: menu closed, positions and timers zero, registers at their defaults.
module stepper_autorepeat_with_debounced_commit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [sadc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [sadc_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // input channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [2:0]                        action_i,
  input  logic [3:0]                        button_i,
  input  logic [sadc_pkg::PRESET_W-1:0]     start_preset_i,
  input  logic [sadc_pkg::WEIGHT_W-1:0]     start_weight_level_i,
  // output channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              handled_o,
  output logic [sadc_pkg::PRESET_W-1:0]     preset_index_o,
  output logic                              preset_stepped_o,
  output logic [sadc_pkg::WEIGHT_W-1:0]     weight_level_o,
  output logic [sadc_pkg::PCT_W-1:0]        weight_percent_o,
  output logic                              weight_stepped_o,
  output logic                              commit_weight_o,
  output logic                              close_request_o,
  output logic                              undo_request_o
);
  import sadc_pkg::*;

  // Configuration registers
  logic [TIMER_W-1:0] repeat_delay_q, repeat_interval_q, commit_debounce_q;
  logic [COUNT_W-1:0] preset_count_q;
  logic               weight_editable_q;

  // Menu state
  logic                menu_open_q, menu_open_d;
  logic [PRESET_W-1:0] preset_pos_q, preset_pos_d;
  logic [WEIGHT_W-1:0] weight_pos_q, weight_pos_d;
  logic [HELD_W-1:0]   held_q, held_d;
  logic                repeat_phase_q, repeat_phase_d;
  logic [TIMER_W-1:0]  repeat_timer_q, repeat_timer_d;
  logic                pending_q, pending_d;
  logic [TIMER_W-1:0]  debounce_q, debounce_d;

  // Output register and skid register
  result_t out_q, skid_q;
  logic    out_valid_q, skid_valid_q;

  // Datapath helpers
  result_t            res;
  action_e            act;
  logic               accept, take_out, stepper, due;
  logic [COUNT_W-1:0] live_cnt;
  logic [PRESET_W-1:0] cur_preset, last_preset, next_fwd, next_back;
  logic [1:0]         step_sel;
  logic               do_step;
  logic               count_nz;

  assign in_stall_o = skid_valid_q;
  assign accept     = in_valid_i & ~skid_valid_q;
  assign take_out   = out_valid_q & ~out_stall_i;
  assign act        = action_e'(action_i);
  assign stepper    = (button_i <= BTN_WEIGHT_NEXT);

  // Clamp preset count and precompute both preset neighbors
  assign live_cnt    = (preset_count_q > SLOTS_CNT) ? SLOTS_CNT : preset_count_q;
  assign count_nz    = (live_cnt != '0);
  assign cur_preset  = ({1'b0, preset_pos_q} < live_cnt) ? preset_pos_q : '0;
  assign last_preset = PRESET_W'(live_cnt - COUNT_W'(1));
  assign next_fwd    = ({1'b0, cur_preset} + COUNT_W'(1) == live_cnt) ? '0
                                                                       : cur_preset + 1'b1;
  assign next_back   = (cur_preset == '0) ? last_preset : cur_preset - 1'b1;

  // Event handling: next state and result
  always_comb begin
    menu_open_d    = menu_open_q;
    preset_pos_d   = preset_pos_q;
    weight_pos_d   = weight_pos_q;
    held_d         = held_q;
    repeat_phase_d = repeat_phase_q;
    repeat_timer_d = repeat_timer_q;
    pending_d      = pending_q;
    debounce_d     = debounce_q;
    res            = '0;
    do_step        = 1'b0;
    step_sel       = '0;
    due            = 1'b0;

    if (act == ACT_OPEN) begin
      menu_open_d  = 1'b1;
      preset_pos_d = (count_nz && ({1'b0, start_preset_i} < live_cnt)) ? start_preset_i : '0;
      weight_pos_d = (start_weight_level_i > WEIGHT_TOP) ? WEIGHT_TOP : start_weight_level_i;
      pending_d    = 1'b0;
    end else if (menu_open_q) begin
      case (act)
        ACT_TICK: begin
          if (held_q != HELD_NONE && repeat_timer_q != TIMER_MAX)
            repeat_timer_d = repeat_timer_q + 1'b1;
          if (pending_q && debounce_q != TIMER_MAX)
            debounce_d = debounce_q + 1'b1;
          due = repeat_phase_q ? (repeat_timer_d >= repeat_interval_q)
                               : (repeat_timer_d >= repeat_delay_q);
          if (held_q != HELD_NONE && due) begin
            repeat_phase_d = 1'b1;
            repeat_timer_d = '0;
            do_step        = 1'b1;
            step_sel       = 2'(held_q - 1'b1);
          end
        end
        ACT_CLOSE: begin
          menu_open_d    = 1'b0;
          held_d         = HELD_NONE;
          repeat_phase_d = 1'b0;
        end
        ACT_PRESS: begin
          if (stepper) begin
            held_d         = HELD_W'(button_i) + 1'b1;
            repeat_timer_d = '0;
            repeat_phase_d = 1'b0;
            do_step        = 1'b1;
            step_sel       = button_i[1:0];
            res.handled    = 1'b1;
          end else if (button_i == BTN_WEIGHT_ICON) begin
            do_step     = 1'b1;
            step_sel    = BTN_WEIGHT_NEXT[1:0];
            res.handled = 1'b1;
          end
        end
        ACT_RELEASE: begin
          if (stepper) begin
            held_d         = HELD_NONE;
            repeat_phase_d = 1'b0;
            res.handled    = 1'b1;
          end else if (button_i == BTN_WEIGHT_ICON || button_i == BTN_PRESET_ICON) begin
            res.handled = 1'b1;
          end else if (button_i == BTN_ANCHOR) begin
            res.close_request = 1'b1;
            res.handled       = 1'b1;
          end else if (button_i == BTN_UNDO) begin
            res.undo_request = 1'b1;
            res.handled      = 1'b1;
          end
        end
        ACT_HOVER_IN: begin
          res.handled = (button_i <= BTN_UNDO);
        end
        ACT_HOVER_OUT: begin
          if (stepper && held_q == HELD_W'(button_i) + 1'b1) begin
            held_d         = HELD_NONE;
            repeat_phase_d = 1'b0;
          end
          res.handled = stepper;
        end
        default: begin
        end
      endcase
    end

    // Stepper action, shared by press and repeat
    if (do_step) begin
      case (step_sel)
        BTN_PRESET_PREV[1:0]: begin
          if (count_nz) begin
            preset_pos_d       = next_back;
            res.preset_stepped = 1'b1;
          end
        end
        BTN_PRESET_NEXT[1:0]: begin
          if (count_nz) begin
            preset_pos_d       = next_fwd;
            res.preset_stepped = 1'b1;
          end
        end
        BTN_WEIGHT_PREV[1:0]: begin
          if (weight_editable_q) begin
            weight_pos_d       = (weight_pos_q == '0) ? WEIGHT_TOP : weight_pos_q - 1'b1;
            pending_d          = 1'b1;
            debounce_d         = '0;
            res.weight_stepped = 1'b1;
          end
        end
        default: begin
          if (weight_editable_q) begin
            weight_pos_d       = (weight_pos_q >= WEIGHT_TOP) ? '0 : weight_pos_q + 1'b1;
            pending_d          = 1'b1;
            debounce_d         = '0;
            res.weight_stepped = 1'b1;
          end
        end
      endcase
    end

    // Commit on debounce expiry or on close
    if (act != ACT_OPEN && menu_open_q) begin
      if (act == ACT_TICK && pending_d && debounce_d >= commit_debounce_q) begin
        pending_d         = 1'b0;
        res.commit_weight = 1'b1;
      end else if (act == ACT_CLOSE && pending_q) begin
        pending_d         = 1'b0;
        res.commit_weight = 1'b1;
      end
    end

    res.preset_index   = count_nz ? preset_pos_d : '0;
    res.weight_level   = weight_pos_d;
    res.weight_percent = level_pct(weight_pos_d);
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      repeat_delay_q    <= 16'd400;
      repeat_interval_q <= 16'd150;
      commit_debounce_q <= 16'd500;
      preset_count_q    <= '0;
      weight_editable_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_REPEAT_DELAY:    repeat_delay_q    <= cfg_data_i;
        CFG_REPEAT_INTERVAL: repeat_interval_q <= cfg_data_i;
        CFG_COMMIT_DEBOUNCE: commit_debounce_q <= cfg_data_i;
        CFG_PRESET_COUNT:    preset_count_q    <= cfg_data_i[COUNT_W-1:0];
        CFG_WEIGHT_EDITABLE: weight_editable_q <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // Menu state, updated per accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      menu_open_q    <= 1'b0;
      preset_pos_q   <= '0;
      weight_pos_q   <= '0;
      held_q         <= HELD_NONE;
      repeat_phase_q <= 1'b0;
      repeat_timer_q <= '0;
      pending_q      <= 1'b0;
      debounce_q     <= '0;
    end else if (accept) begin
      menu_open_q    <= menu_open_d;
      preset_pos_q   <= preset_pos_d;
      weight_pos_q   <= weight_pos_d;
      held_q         <= held_d;
      repeat_phase_q <= repeat_phase_d;
      repeat_timer_q <= repeat_timer_d;
      pending_q      <= pending_d;
      debounce_q     <= debounce_d;
    end
  end

  // Output register with one skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (take_out || !out_valid_q) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= accept;
      end
    end else if (accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (take_out || !out_valid_q) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (accept) begin
        out_q <= res;
      end
    end else if (accept) begin
      skid_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign handled_o        = out_q.handled;
  assign preset_index_o   = out_q.preset_index;
  assign preset_stepped_o = out_q.preset_stepped;
  assign weight_level_o   = out_q.weight_level;
  assign weight_percent_o = out_q.weight_percent;
  assign weight_stepped_o = out_q.weight_stepped;
  assign commit_weight_o  = out_q.commit_weight;
  assign close_request_o  = out_q.close_request;
  assign undo_request_o   = out_q.undo_request;

endmodule
